// File: rtl/adamu_pkg.sv
// Adam update package: payload structs, configuration and pipeline tag types, constants.
// Depends on nothing; used by adamu_front, adamu_back, the top level and the testbench.
`default_nettype none
package adamu_pkg;

    localparam int DataWidth = 32;

    localparam logic [32:0] OneQ32  = 33'h1_0000_0000;
    localparam logic [63:0] StepCap = 64'h4000_0000_0000_0000;

    typedef enum logic [1:0] {
        CFG_LEARN_RATE    = 2'd0,
        CFG_DECAY_FIRST   = 2'd1,
        CFG_DECAY_SECOND  = 2'd2,
        CFG_STABILITY_EPS = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [DataWidth-1:0] weight_in;
        logic signed [31:0]          gradient;
        logic signed [31:0]          moment1_in;
        logic [47:0]                 moment2_in;
        logic                        first_element;
    } t_in;

    typedef struct packed {
        logic signed [DataWidth-1:0] weight_out;
        logic signed [31:0]          moment1_out;
        logic [47:0]                 moment2_out;
        logic                        saturated;
    } t_out;

    typedef struct packed {
        logic [31:0] learn_rate;
        logic [31:0] decay_first;
        logic [31:0] decay_second;
        logic [30:0] stability_eps;
    } t_cfg;

    typedef struct packed {
        logic signed [DataWidth-1:0] w;
        logic signed [31:0]          g;
        logic signed [31:0]          m;
        logic [47:0]                 v;
        logic [32:0]                 d1;
        logic [32:0]                 d2;
    } t_job;

    typedef struct packed {
        logic signed [DataWidth-1:0] w;
        logic signed [31:0]          mn;
        logic [47:0]                 vn;
        logic                        sat;
    } t_elem;

    typedef struct packed {
        t_elem       elem;
        logic [32:0] d2;
    } t_tag1;

    typedef struct packed {
        t_elem       elem;
        logic [63:0] mhat;
    } t_tag2;

endpackage
`default_nettype wire

// File: rtl/adamu_fifo.sv
// Small flop queue between the front and back of the Adam update.
// Generic width and depth; no package dependency.
`default_nettype none
module adamu_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_full,
    output logic                  o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd, n_wr, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             push_ok, pop_ok;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push_ok) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (pop_ok) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (push_ok && !pop_ok) begin
            n_cnt = r_cnt + CW'(1);
        end else if (pop_ok && !push_ok) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule
`default_nettype wire

// File: rtl/adamu_front.sv
// Front of the Adam update: configuration registers, step counter, beta powers.
// Turns each input transaction into a queue job with bias denominators; uses adamu_pkg.
`default_nettype none
module adamu_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [31:0]   i_cfg_data,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire adamu_pkg::t_in i_in,
    input  wire logic          i_q_full,
    output logic               o_push,
    output adamu_pkg::t_job    o_job,
    output adamu_pkg::t_cfg    o_cfg
);
    adamu_pkg::t_cfg r_cfg;
    logic [31:0]     r_step_count;
    logic [32:0]     r_b1p, r_b2p, n_b1p, n_b2p;
    logic [64:0]     prod1, prod2;
    logic [32:0]     d1_raw, d2_raw;
    logic            take;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !i_q_full;
    assign take        = i_in_valid && !i_q_full;
    assign o_push      = take;
    assign o_cfg       = r_cfg;

    assign prod1 = r_b1p * r_cfg.decay_first;
    assign prod2 = r_b2p * r_cfg.decay_second;

    always_comb begin
        n_b1p = r_b1p;
        n_b2p = r_b2p;
        if (i_in.first_element) begin
            n_b1p = prod1[64:32];
            n_b2p = prod2[64:32];
        end
        d1_raw = adamu_pkg::OneQ32 - n_b1p;
        d2_raw = adamu_pkg::OneQ32 - n_b2p;
        o_job.w  = i_in.weight_in;
        o_job.g  = i_in.gradient;
        o_job.m  = i_in.moment1_in;
        o_job.v  = i_in.moment2_in;
        o_job.d1 = (d1_raw == '0) ? adamu_pkg::OneQ32 : d1_raw;
        o_job.d2 = (d2_raw == '0) ? adamu_pkg::OneQ32 : d2_raw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.learn_rate    <= 32'd4294967;
            r_cfg.decay_first   <= 32'd3865470566;
            r_cfg.decay_second  <= 32'd4290672329;
            r_cfg.stability_eps <= 31'd3;
            r_step_count        <= '0;
            r_b1p               <= adamu_pkg::OneQ32;
            r_b2p               <= adamu_pkg::OneQ32;
        end else begin
            if (i_cfg_valid) begin
                case (adamu_pkg::t_cfg_idx'(i_cfg_index))
                    adamu_pkg::CFG_LEARN_RATE:    r_cfg.learn_rate    <= i_cfg_data;
                    adamu_pkg::CFG_DECAY_FIRST:   r_cfg.decay_first   <= i_cfg_data;
                    adamu_pkg::CFG_DECAY_SECOND:  r_cfg.decay_second  <= i_cfg_data;
                    adamu_pkg::CFG_STABILITY_EPS: r_cfg.stability_eps <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (take && i_in.first_element) begin
                r_step_count <= r_step_count + 32'd1;
                r_b1p        <= n_b1p;
                r_b2p        <= n_b2p;
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/adamu_div.sv
// Pipelined restoring divider, one quotient bit per stage, 64-bit quotient clipped to all ones.
// Carries a generic tag alongside; no package dependency.
`default_nettype none
module adamu_div #(
    parameter int HI_W  = 1,
    parameter int DEN_W = 33,
    parameter int TAG_W = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_vld,
    input  wire logic [HI_W-1:0]  i_hi,
    input  wire logic [63:0]      i_lo,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire logic [TAG_W-1:0] i_tag,
    output logic                  o_vld,
    output logic [63:0]           o_quo,
    output logic [TAG_W-1:0]      o_tag
);
    logic [DEN_W-1:0] r_rem  [65];
    logic [63:0]      r_lo   [65];
    logic [63:0]      r_q    [65];
    logic [DEN_W-1:0] r_den  [65];
    logic             r_clip [65];
    logic [TAG_W-1:0] r_tag  [65];
    logic             r_vld  [65];
    logic [DEN_W-1:0] hi_ext;

    assign hi_ext = {{(DEN_W-HI_W){1'b0}}, i_hi};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= hi_ext;
            r_lo[0]   <= i_lo;
            r_q[0]    <= '0;
            r_den[0]  <= i_den;
            r_clip[0] <= (hi_ext >= i_den);
            r_tag[0]  <= i_tag;
        end
    end

    for (genvar k = 1; k <= 64; k++) begin : g_stage
        logic [DEN_W:0] rem2;
        logic           ge;
        logic [DEN_W:0] diff;

        assign rem2 = {r_rem[k-1], r_lo[k-1][63]};
        assign ge   = (rem2 >= {1'b0, r_den[k-1]});
        assign diff = rem2 - {1'b0, r_den[k-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
                r_lo[k]   <= {r_lo[k-1][62:0], 1'b0};
                r_q[k]    <= {r_q[k-1][62:0], ge};
                r_den[k]  <= r_den[k-1];
                r_clip[k] <= r_clip[k-1];
                r_tag[k]  <= r_tag[k-1];
            end
        end
    end

    assign o_vld = r_vld[64];
    assign o_quo = r_clip[64] ? '1 : r_q[64];
    assign o_tag = r_tag[64];
endmodule
`default_nettype wire

// File: rtl/adamu_sqrt.sv
// Pipelined integer square root of a 64-bit value scaled by 2^14, one root bit per stage.
// Carries a generic tag alongside; no package dependency.
`default_nettype none
module adamu_sqrt #(
    parameter int TAG_W = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_vld,
    input  wire logic [63:0]      i_val,
    input  wire logic [TAG_W-1:0] i_tag,
    output logic                  o_vld,
    output logic [39:0]           o_root,
    output logic [TAG_W-1:0]      o_tag
);
    logic [79:0]      r_rem  [41];
    logic [39:0]      r_root [41];
    logic [TAG_W-1:0] r_tag  [41];
    logic             r_vld  [41];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= {2'b0, i_val, 14'b0};
            r_root[0] <= '0;
            r_tag[0]  <= i_tag;
        end
    end

    for (genvar i = 1; i <= 40; i++) begin : g_stage
        localparam int B = 40 - i;
        logic [79:0] trial;
        logic        ge;

        assign trial = ({40'b0, r_root[i-1]} << (B + 1)) + (80'd1 << (2 * B));
        assign ge    = (r_rem[i-1] >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_vld[i] <= r_vld[i-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i]  <= ge ? r_rem[i-1] - trial : r_rem[i-1];
                r_root[i] <= ge ? (r_root[i-1] | (40'd1 << B)) : r_root[i-1];
                r_tag[i]  <= r_tag[i-1];
            end
        end
    end

    assign o_vld  = r_vld[40];
    assign o_root = r_root[40];
    assign o_tag  = r_tag[40];
endmodule
`default_nettype wire

// File: rtl/adamu_back.sv
// Back of the Adam update: moment updates, bias correction, root, step and weight saturation.
// Uses adamu_pkg, adamu_div and adamu_sqrt; whole pipeline holds while the output stalls.
`default_nettype none
module adamu_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire adamu_pkg::t_cfg i_cfg,
    input  wire adamu_pkg::t_job i_job,
    input  wire logic            i_job_vld,
    output logic                 o_job_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output adamu_pkg::t_out      o_out
);
    localparam int DW = adamu_pkg::DataWidth;

    logic adv;

    logic                 r_s1_vld, r_s2_vld, r_s3_vld, r_den_vld, r_out_vld;
    logic signed [64:0]   r_pm1;
    logic signed [65:0]   r_pm2;
    logic [48:0]          r_gsq;
    logic [63:0]          r_pv_lo, r_pv2_lo;
    logic [47:0]          r_pv_hi, r_pv2_hi;
    logic signed [DW-1:0] r_s1_w, r_s2_w;
    logic [32:0]          r_s1_d1, r_s1_d2, r_s2_d1, r_s2_d2, r_s3_d1;
    logic signed [31:0]   r_s2_mn;
    logic [64:0]          r_pg_lo;
    logic [49:0]          r_pg_hi;
    logic [31:0]          r_mmag;
    adamu_pkg::t_tag1     r_s3_tag;

    logic [31:0]          gmag;
    logic [63:0]          gsq_full;
    logic [32:0]          c1, c2;
    logic signed [66:0]   msum;
    logic [81:0]          vsum;
    logic [49:0]          vn_raw;

    logic                 d1_vld, d2_vld, sq_vld, d3_vld;
    logic [63:0]          d1_quo, d2_quo, d3_quo;
    adamu_pkg::t_tag1     d1_tag;
    adamu_pkg::t_tag2     d2_in_tag, d2_tag, sq_tag;
    logic [39:0]          sq_root;

    logic [40:0]          r_den, den_sum;
    logic [63:0]          r_pl_lo, r_pl_hi;
    adamu_pkg::t_elem     r_den_elem, d3_tag;
    logic [95:0]          num;

    logic [63:0]          step;
    logic [DW-1:0]        top, gap_pos, gap_neg, gap;
    logic                 over;
    logic signed [DW-1:0] wn;
    adamu_pkg::t_out      r_out, n_out;

    assign adv         = !r_out_vld || i_out_ready;
    assign o_job_pop   = adv && i_job_vld;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    assign c1       = adamu_pkg::OneQ32 - {1'b0, i_cfg.decay_first};
    assign c2       = adamu_pkg::OneQ32 - {1'b0, i_cfg.decay_second};
    assign gmag     = i_job.g[31] ? (~i_job.g + 32'd1) : i_job.g;
    assign gsq_full = gmag * gmag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_den_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld  <= i_job_vld;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_den_vld <= sq_vld;
            r_out_vld <= d3_vld;
        end
    end

    assign msum   = 67'(r_pm1) + 67'(r_pm2);
    assign vsum   = 82'(r_pv2_lo) + 82'({r_pv2_hi, 32'b0}) + 82'(r_pg_lo)
                  + 82'({r_pg_hi, 32'b0});
    assign vn_raw = vsum[81:32];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pm1    <= $signed({1'b0, i_cfg.decay_first}) * i_job.m;
            r_pm2    <= $signed({1'b0, c1}) * i_job.g;
            r_gsq    <= gsq_full[62:14];
            r_pv_lo  <= i_cfg.decay_second * i_job.v[31:0];
            r_pv_hi  <= i_cfg.decay_second * i_job.v[47:32];
            r_s1_w   <= i_job.w;
            r_s1_d1  <= i_job.d1;
            r_s1_d2  <= i_job.d2;

            r_s2_mn  <= msum[63:32];
            r_pg_lo  <= c2 * r_gsq[31:0];
            r_pg_hi  <= c2 * r_gsq[48:32];
            r_pv2_lo <= r_pv_lo;
            r_pv2_hi <= r_pv_hi;
            r_s2_w   <= r_s1_w;
            r_s2_d1  <= r_s1_d1;
            r_s2_d2  <= r_s1_d2;

            r_s3_tag.elem.w   <= r_s2_w;
            r_s3_tag.elem.mn  <= r_s2_mn;
            r_s3_tag.elem.vn  <= (vn_raw[49:48] != 2'b0) ? '1 : vn_raw[47:0];
            r_s3_tag.elem.sat <= (vn_raw[49:48] != 2'b0);
            r_s3_tag.d2       <= r_s2_d2;
            r_mmag            <= r_s2_mn[31] ? (~r_s2_mn + 32'd1) : r_s2_mn;
            r_s3_d1           <= r_s2_d1;
        end
    end

    adamu_div #(
        .HI_W  (1),
        .DEN_W (33),
        .TAG_W ($bits(adamu_pkg::t_tag1))
    ) u_div_m (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (r_s3_vld),
        .i_hi    (1'b0),
        .i_lo    ({r_mmag, 32'b0}),
        .i_den   (r_s3_d1),
        .i_tag   (r_s3_tag),
        .o_vld   (d1_vld),
        .o_quo   (d1_quo),
        .o_tag   (d1_tag)
    );

    assign d2_in_tag.elem = d1_tag.elem;
    assign d2_in_tag.mhat = d1_quo;

    adamu_div #(
        .HI_W  (16),
        .DEN_W (33),
        .TAG_W ($bits(adamu_pkg::t_tag2))
    ) u_div_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (d1_vld),
        .i_hi    (d1_tag.elem.vn[47:32]),
        .i_lo    ({d1_tag.elem.vn[31:0], 32'b0}),
        .i_den   (d1_tag.d2),
        .i_tag   (d2_in_tag),
        .o_vld   (d2_vld),
        .o_quo   (d2_quo),
        .o_tag   (d2_tag)
    );

    adamu_sqrt #(
        .TAG_W ($bits(adamu_pkg::t_tag2))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (d2_vld),
        .i_val   (d2_quo),
        .i_tag   (d2_tag),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_tag   (sq_tag)
    );

    assign den_sum = 41'(sq_root) + 41'(i_cfg.stability_eps);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_den      <= (den_sum == '0) ? 41'd1 : den_sum;
            r_pl_lo    <= i_cfg.learn_rate * sq_tag.mhat[31:0];
            r_pl_hi    <= i_cfg.learn_rate * sq_tag.mhat[63:32];
            r_den_elem <= sq_tag.elem;
        end
    end

    assign num = 96'(r_pl_lo) + {r_pl_hi, 32'b0};

    adamu_div #(
        .HI_W  (28),
        .DEN_W (41),
        .TAG_W ($bits(adamu_pkg::t_elem))
    ) u_div_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (r_den_vld),
        .i_hi    (num[95:68]),
        .i_lo    (num[67:4]),
        .i_den   (r_den),
        .i_tag   (r_den_elem),
        .o_vld   (d3_vld),
        .o_quo   (d3_quo),
        .o_tag   (d3_tag)
    );

    always_comb begin
        step    = (d3_quo > adamu_pkg::StepCap) ? adamu_pkg::StepCap : d3_quo;
        top     = {1'b1, {(DW-1){1'b0}}};
        gap_pos = d3_tag.w ^ top;
        gap_neg = ~d3_tag.w ^ top;
        gap     = d3_tag.mn[31] ? gap_neg : gap_pos;
        over    = ({1'b0, step} > {{(65-DW){1'b0}}, gap});
        if (!d3_tag.mn[31]) begin
            wn = over ? $signed(top) : d3_tag.w - $signed(step[DW-1:0]);
        end else begin
            wn = over ? $signed(~top) : d3_tag.w + $signed(step[DW-1:0]);
        end
        n_out.weight_out  = wn;
        n_out.moment1_out = d3_tag.mn;
        n_out.moment2_out = d3_tag.vn;
        n_out.saturated   = d3_tag.sat || over;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end
endmodule
`default_nettype wire

// File: rtl/adam_param_update.sv
// Adam parameter update, one tensor element per transaction; top level.
// Throughput one element per cycle while the output does not stall; the back holds three
// pipelined dividers (64 stages each) in line and a 40-stage square root.
// A stalled output holds the whole back pipeline; the queue keeps accepting until full.
// Reset (synchronous, active low) restores register defaults, step count 0, beta powers 1.0.
`default_nettype none
module adam_param_update #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [1:0]      i_cfg_index,
    input  wire logic [31:0]     i_cfg_data,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire adamu_pkg::t_in  i_in,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output adamu_pkg::t_out      o_out
);
    adamu_pkg::t_cfg cfg;
    adamu_pkg::t_job push_job, head_job;
    logic            push, pop, q_full, q_empty;

    adamu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_job       (push_job),
        .o_cfg       (cfg)
    );

    adamu_fifo #(
        .WIDTH ($bits(adamu_pkg::t_job)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .i_pop   (pop),
        .o_data  (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    adamu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job       (head_job),
        .i_job_vld   (!q_empty),
        .o_job_pop   (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );
endmodule
`default_nettype wire

// File: sim/adam_param_update_tb.sv
// Self-checking testbench for adam_param_update: random and directed Adam element updates.
// Depends on adamu_pkg and the adam_param_update RTL; predicts every result in place.
`default_nettype none
module adam_param_update_tb;

    localparam int LATENCY   = 241;
    localparam int WDOG_MAX  = 4000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index;
    logic [31:0]       i_cfg_data;
    logic              i_in_valid;
    logic              o_in_ready;
    adamu_pkg::t_in    i_in;
    logic              o_out_valid;
    logic              i_out_ready;
    adamu_pkg::t_out   o_out;

    adam_param_update uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out)
    );

    // predictor state
    logic [31:0] lr_q, b1_q, b2_q;
    logic [30:0] eps_q;
    logic [31:0] steps_q;
    logic [32:0] b1pow_q, b2pow_q;

    adamu_pkg::t_in  elem_queue[$];
    adamu_pkg::t_out update_queue[$];
    int   errors;
    bit   quiet_mode;
    int   idle_in, idle_out;
    int   wdog;

    function automatic logic [63:0] div_clip(logic [127:0] num, logic [63:0] d);
        logic [127:0] q;
        q = num / d;
        if (q[127:64] != 0) return '1;
        return q[63:0];
    endfunction

    function automatic logic [63:0] isqrt80(logic [79:0] x);
        logic [39:0]  r;
        logic [39:0]  c;
        r = '0;
        for (int b = 39; b >= 0; b--) begin
            c = r | (40'd1 << b);
            if ({40'd0, c} * {40'd0, c} <= x) r = c;
        end
        return {24'd0, r};
    endfunction

    task automatic predict_update(input adamu_pkg::t_in it);
        logic signed [63:0]  w, g, m, wmax, wmin, wn;
        logic signed [127:0] macc;
        logic signed [63:0]  mn;
        logic [63:0]  gmag, gsq, mmag, mhat, vhat, root, den, step, gap;
        logic [127:0] vacc, sacc;
        logic [63:0]  vn;
        logic [32:0]  d1, d2;
        logic         sat;
        adamu_pkg::t_out r;
        if (it.first_element) begin
            steps_q = steps_q + 1;
            b1pow_q = 33'(({31'd0, b1pow_q} * {32'd0, b1_q}) >> 32);
            b2pow_q = 33'(({31'd0, b2pow_q} * {32'd0, b2_q}) >> 32);
        end
        w = it.weight_in;
        g = it.gradient;
        m = it.moment1_in;
        sat = 0;
        macc = $signed({64'd0, 32'd0, b1_q}) * m
             + $signed({64'd0, 64'h1_0000_0000 - b1_q}) * g;
        mn = 64'(macc >>> 32);
        gmag = g < 0 ? -g : g;
        gsq = (gmag * gmag) >> 14;
        vacc = {96'd0, b2_q} * {80'd0, it.moment2_in}
             + {64'd0, 64'h1_0000_0000 - b2_q} * {64'd0, gsq};
        vacc = vacc >> 32;
        if (vacc > 128'hFFFF_FFFF_FFFF) begin
            vn = 64'hFFFF_FFFF_FFFF;
            sat = 1;
        end else vn = vacc[63:0];
        d1 = adamu_pkg::OneQ32 - b1pow_q;
        if (d1 == 0) d1 = adamu_pkg::OneQ32;
        d2 = adamu_pkg::OneQ32 - b2pow_q;
        if (d2 == 0) d2 = adamu_pkg::OneQ32;
        mmag = mn < 0 ? -mn : mn;
        mhat = div_clip({64'd0, mmag} << 32, {31'd0, d1});
        vhat = div_clip({64'd0, vn} << 32, {31'd0, d2});
        root = isqrt80({16'd0, vhat} << 14);
        den = root + eps_q;
        if (den == 0) den = 1;
        sacc = ({96'd0, lr_q} * {64'd0, mhat}) >> 4;
        step = div_clip(sacc, den);
        if (step > adamu_pkg::StepCap) step = adamu_pkg::StepCap;
        wmax = 64'sh7FFF_FFFF;
        wmin = -wmax - 1;
        if (mn >= 0) begin
            gap = w - wmin;
            if (step > gap) begin wn = wmin; sat = 1; end
            else wn = w - $signed(step);
        end else begin
            gap = wmax - w;
            if (step > gap) begin wn = wmax; sat = 1; end
            else wn = w + $signed(step);
        end
        r.weight_out  = wn[31:0];
        r.moment1_out = mn[31:0];
        r.moment2_out = vn[47:0];
        r.saturated   = sat;
        update_queue.push_back(r);
    endtask

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 0;
            idle_in = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_update(i_in);
                void'(elem_queue.pop_front());
            end
            if (idle_in > 0) idle_in--;
            else if (!quiet_mode && $urandom_range(0, 15) == 0)
                idle_in = $urandom_range(1, 8);
            if (!i_in_valid || o_in_ready) begin
                if (elem_queue.size() > 0 && idle_in == 0) begin
                    i_in_valid <= 1;
                    i_in <= elem_queue[0];
                end else i_in_valid <= 0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 0;
            idle_out = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (update_queue.size() == 0) begin
                    $error("unexpected result transaction");
                    errors++;
                end else begin
                    adamu_pkg::t_out e;
                    e = update_queue.pop_front();
                    if (o_out.weight_out !== e.weight_out) begin
                        $error("weight_out exp %h got %h", e.weight_out, o_out.weight_out);
                        errors++;
                    end
                    if (o_out.moment1_out !== e.moment1_out) begin
                        $error("moment1_out exp %h got %h", e.moment1_out, o_out.moment1_out);
                        errors++;
                    end
                    if (o_out.moment2_out !== e.moment2_out) begin
                        $error("moment2_out exp %h got %h", e.moment2_out, o_out.moment2_out);
                        errors++;
                    end
                    if (o_out.saturated !== e.saturated) begin
                        $error("saturated exp %b got %b", e.saturated, o_out.saturated);
                        errors++;
                    end
                end
            end
            if (idle_out > 0) idle_out--;
            else if (!quiet_mode && $urandom_range(0, 15) == 0)
                idle_out = $urandom_range(1, 8);
            i_out_ready <= (idle_out == 0);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) wdog <= 0;
        else if (wdog >= WDOG_MAX) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else wdog <= wdog + 1;
    end

    task automatic write_reg(input adamu_pkg::t_cfg_idx idx, input logic [31:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        case (idx)
            adamu_pkg::CFG_LEARN_RATE:    lr_q = val;
            adamu_pkg::CFG_DECAY_FIRST:   b1_q = val;
            adamu_pkg::CFG_DECAY_SECOND:  b2_q = val;
            adamu_pkg::CFG_STABILITY_EPS: eps_q = val[30:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain_pipe();
        while (elem_queue.size() > 0 || update_queue.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
    endtask

    function automatic adamu_pkg::t_in rand_elem(bit well_formed, bit first);
        adamu_pkg::t_in it;
        it.weight_in  = $urandom;
        it.gradient   = $urandom;
        it.moment1_in = $urandom;
        it.moment2_in = {16'($urandom), 32'($urandom)};
        if (well_formed) begin
            it.gradient   = $signed(it.gradient) >>> $urandom_range(0, 31);
            it.moment1_in = $signed(it.moment1_in) >>> $urandom_range(0, 31);
            it.moment2_in = it.moment2_in >> $urandom_range(0, 47);
        end
        it.first_element = first;
        return it;
    endfunction

    task automatic push_call(int n);
        for (int k = 0; k < n; k++)
            elem_queue.push_back(rand_elem($urandom_range(0, 9) != 0,
                                 k == 0 || $urandom_range(0, 49) == 0));
    endtask

    task automatic push_dir(logic [31:0] w, logic [31:0] g, logic [31:0] m,
                            logic [47:0] v, logic f);
        adamu_pkg::t_in it;
        it.weight_in = w; it.gradient = g; it.moment1_in = m;
        it.moment2_in = v; it.first_element = f;
        elem_queue.push_back(it);
    endtask

    initial begin
        errors = 0;
        quiet_mode = 0;
        i_rst_n = 0;
        i_cfg_valid = 0;
        i_cfg_index = adamu_pkg::CFG_LEARN_RATE;
        i_cfg_data = 0;
        i_in_valid = 0;
        i_in = '0;
        i_out_ready = 0;
        wdog = 0;
        lr_q = 32'd4294967; b1_q = 32'd3865470566; b2_q = 32'd4290672329; eps_q = 31'd3;
        steps_q = 0; b1pow_q = adamu_pkg::OneQ32; b2pow_q = adamu_pkg::OneQ32;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // no first element yet for the leading two: no bias correction; later first elements start it
        push_dir(32'h0, 32'h0, 32'h0, 48'h0, 0);
        push_dir(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 48'hFFFF_FFFF_FFFF, 0);
        push_dir(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF, 1);
        push_dir(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 48'h0, 0);
        push_dir(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 48'h0, 1);
        push_dir(32'h1000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 48'h1, 0);
        push_dir(32'hF000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 48'h0, 1);
        drain_pipe();

        // extreme settings: zero epsilon, zero decays, max rate
        write_reg(adamu_pkg::CFG_LEARN_RATE, 32'hFFFF_FFFF);
        write_reg(adamu_pkg::CFG_STABILITY_EPS, 32'h0);
        write_reg(adamu_pkg::CFG_DECAY_FIRST, 32'h0);
        write_reg(adamu_pkg::CFG_DECAY_SECOND, 32'h0);
        push_dir(32'h0, 32'h0, 32'h0, 48'h0, 1);
        push_dir(32'h0, 32'h0000_0001, 32'h0, 48'h0, 0);
        push_dir(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 48'h0, 1);
        push_dir(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 48'hFFFF_FFFF_FFFF, 0);
        push_call(6);
        drain_pipe();

        // beta equal to one in effect: max decay, max epsilon, zero rate
        write_reg(adamu_pkg::CFG_DECAY_FIRST, 32'hFFFF_FFFF);
        write_reg(adamu_pkg::CFG_DECAY_SECOND, 32'hFFFF_FFFF);
        write_reg(adamu_pkg::CFG_STABILITY_EPS, 32'h7FFF_FFFF);
        write_reg(adamu_pkg::CFG_LEARN_RATE, 32'h0);
        push_call(8);
        drain_pipe();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(adamu_pkg::CFG_LEARN_RATE, $urandom);
            write_reg(adamu_pkg::CFG_DECAY_FIRST,
                      ph[0] ? $urandom : 32'hE666_6666 + $urandom_range(0, 255));
            write_reg(adamu_pkg::CFG_DECAY_SECOND,
                      ph[1] ? $urandom : 32'hFFBE_76C9 - $urandom_range(0, 255));
            write_reg(adamu_pkg::CFG_STABILITY_EPS,
                      $urandom_range(0, 15) == 0 ? $urandom : $urandom_range(0, 7));
            if (ph == 5) quiet_mode = 1;
            for (int c = 0; c < 6; c++) push_call($urandom_range(1, 60));
            drain_pipe();
        end

        // restore the defaults
        write_reg(adamu_pkg::CFG_LEARN_RATE, 32'd4294967);
        write_reg(adamu_pkg::CFG_DECAY_FIRST, 32'd3865470566);
        write_reg(adamu_pkg::CFG_DECAY_SECOND, 32'd4290672329);
        write_reg(adamu_pkg::CFG_STABILITY_EPS, 32'd3);
        push_call(40);
        drain_pipe();

        if (errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
